### rtl/bptc_pkg.sv
// Shared widths, constants and types of the barometric compensation core.
// Used by every module in rtl/; depends on nothing.
package bptc_pkg;

  // Field widths
  localparam int RAW_W    = 24;  // raw converter readings
  localparam int CAL_W    = 16;  // calibration words
  localparam int DT_W     = 25;  // D2 - C5*256, signed
  localparam int PROD_W   = 41;  // dT times a calibration word, signed
  localparam int DD_W     = 49;  // dT squared, signed product
  localparam int TEMP_W   = 19;  // temperature in 0.01 C, signed
  localparam int LOW_W    = 18;  // TEMP - 2000 before correction, signed
  localparam int OFF1_W   = 35;  // first-order offset, signed
  localparam int SENS1_W  = 34;  // first-order sensitivity, signed
  localparam int T2_W     = 17;  // temperature correction, unsigned
  localparam int SQ_W     = 35;  // squares of the cold deltas, unsigned
  localparam int CORR_W   = 38;  // OFF2 / SENS2, unsigned
  localparam int FIN_W    = 40;  // corrected offset / sensitivity, signed
  localparam int SPLIT_W  = 20;  // low slice of SENS for the split multiply
  localparam int PL_W     = 44;  // D1 * low slice, unsigned
  localparam int PH_W     = 45;  // D1 * high slice, signed
  localparam int WIDE_W   = 64;  // D1 * SENS, signed
  localparam int Q_W      = 43;  // D1 * SENS / 2^21, signed
  localparam int X_W      = 44;  // quotient minus offset, signed
  localparam int PRESS_W  = 27;  // pressure in Pa, signed
  localparam int IDX_W    = 3;   // configuration register index

  // Arithmetic constants
  localparam int TEMP_REF    = 2000;  // 20.00 C
  localparam int COLD_LIMIT  = 1500;  // -15.00 C is -COLD_LIMIT
  localparam int TEMP_SHIFT  = 23;
  localparam int OFF_SHIFT   = 7;
  localparam int SENS_SHIFT  = 8;
  localparam int T2_SHIFT    = 31;
  localparam int C5_SHIFT    = 8;
  localparam int C2_SHIFT    = 16;
  localparam int C1_SHIFT    = 15;
  localparam int SENS_DIV_SH = 21;    // divide by 2097152
  localparam int PRESS_SH    = 15;    // divide by 32768

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_PRESSURE_SENSITIVITY  = 3'd0,
    REG_PRESSURE_OFFSET       = 3'd1,
    REG_SENSITIVITY_TEMP_COEF = 3'd2,
    REG_OFFSET_TEMP_COEF      = 3'd3,
    REG_REFERENCE_TEMPERATURE = 3'd4,
    REG_TEMPERATURE_SLOPE     = 3'd5
  } cal_reg_t;

  localparam logic [IDX_W-1:0] REG_COUNT = 3'd6;

  // Calibration words as seen by the datapath
  typedef struct packed {
    logic [CAL_W-1:0] pressure_sensitivity;
    logic [CAL_W-1:0] pressure_offset;
    logic [CAL_W-1:0] sensitivity_temp_coef;
    logic [CAL_W-1:0] offset_temp_coef;
    logic [CAL_W-1:0] reference_temperature;
    logic [CAL_W-1:0] temperature_slope;
  } cal_t;

  // First-order results handed to the cold correction
  typedef struct packed {
    logic        [RAW_W-1:0]   d1;
    logic signed [TEMP_W-1:0]  temp1;
    logic signed [LOW_W-1:0]   low;
    logic signed [TEMP_W-1:0]  vlow;
    logic signed [OFF1_W-1:0]  off1;
    logic signed [SENS1_W-1:0] sens1;
    logic        [T2_W-1:0]    t2;
  } front_t;

  // Corrected values handed to the pressure stage
  typedef struct packed {
    logic        [RAW_W-1:0]  d1;
    logic signed [TEMP_W-1:0] temp;
    logic signed [FIN_W-1:0]  off;
    logic signed [FIN_W-1:0]  sens;
  } corr_t;

endpackage

### rtl/bptc_front.sv
// First-order compensation: dT, the four dT products, TEMP/OFF/SENS.
// Three pipeline stages; depends on bptc_pkg.
module bptc_front import bptc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cal_t             cal,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [RAW_W-1:0] in_d1,
  input  logic [RAW_W-1:0] in_d2,
  output logic             out_valid,
  input  logic             out_ready,
  output front_t           out_data
);

  logic a_v_r, b_v_r, c_v_r;
  logic rdy_a, rdy_b, rdy_c;

  // Stage A: dT
  logic        [RAW_W-1:0]  a_d1_r;
  logic signed [DT_W-1:0]   a_dt_r, a_dt_nxt;

  // Stage B: products
  logic        [RAW_W-1:0]  b_d1_r;
  logic signed [PROD_W-1:0] b_pt_r, b_pt_nxt;
  logic signed [PROD_W-1:0] b_poff_r, b_poff_nxt;
  logic signed [PROD_W-1:0] b_psens_r, b_psens_nxt;
  logic signed [DD_W-1:0]   b_dd_r, b_dd_nxt;

  // Stage C: first-order values
  front_t c_r, c_nxt;
  logic signed [LOW_W-1:0]      low_c;
  logic signed [OFF1_W-2:0]     off_tail;
  logic signed [SENS1_W-2:0]    sens_tail;

  // Ready chain, back to front
  assign rdy_c    = !c_v_r || out_ready;
  assign rdy_b    = !b_v_r || rdy_c;
  assign rdy_a    = !a_v_r || rdy_b;
  assign in_ready = rdy_a;

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else begin
      if (rdy_a) a_v_r <= in_valid;
      if (rdy_b) b_v_r <= a_v_r;
      if (rdy_c) c_v_r <= b_v_r;
    end
  end

  // dT = D2 - C5*256
  assign a_dt_nxt = $signed({1'b0, in_d2}) -
                    $signed({1'b0, cal.reference_temperature, {C5_SHIFT{1'b0}}});

  // dT products
  assign b_pt_nxt    = a_dt_r * $signed({1'b0, cal.temperature_slope});
  assign b_poff_nxt  = a_dt_r * $signed({1'b0, cal.offset_temp_coef});
  assign b_psens_nxt = a_dt_r * $signed({1'b0, cal.sensitivity_temp_coef});
  assign b_dd_nxt    = a_dt_r * a_dt_r;

  // Floor shifts are plain bit slices of the signed products
  always_comb begin
    low_c     = $signed(b_pt_r[PROD_W-1:TEMP_SHIFT]);
    off_tail  = $signed(b_poff_r[PROD_W-1:OFF_SHIFT]);
    sens_tail = $signed(b_psens_r[PROD_W-1:SENS_SHIFT]);
    c_nxt.d1    = b_d1_r;
    c_nxt.low   = low_c;
    c_nxt.temp1 = TEMP_W'(low_c) + TEMP_W'(TEMP_REF);
    c_nxt.vlow  = TEMP_W'(low_c) + TEMP_W'(TEMP_REF + COLD_LIMIT);
    c_nxt.off1  = $signed({3'b000, cal.pressure_offset, {C2_SHIFT{1'b0}}}) +
                  OFF1_W'(off_tail);
    c_nxt.sens1 = $signed({3'b000, cal.pressure_sensitivity, {C1_SHIFT{1'b0}}}) +
                  SENS1_W'(sens_tail);
    c_nxt.t2    = b_dd_r[T2_SHIFT+T2_W-1:T2_SHIFT];
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (rdy_a && in_valid) begin
      a_d1_r <= in_d1;
      a_dt_r <= a_dt_nxt;
    end
    if (rdy_b && a_v_r) begin
      b_d1_r    <= a_d1_r;
      b_pt_r    <= b_pt_nxt;
      b_poff_r  <= b_poff_nxt;
      b_psens_r <= b_psens_nxt;
      b_dd_r    <= b_dd_nxt;
    end
    if (rdy_c && b_v_r) begin
      c_r <= c_nxt;
    end
  end

  assign out_valid = c_v_r;
  assign out_data  = c_r;

`ifndef NO_ASSERTIONS
  // A held stage A keeps its dT until stage B takes it
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    a_v_r && !rdy_b |=> a_v_r && $stable(a_dt_r))
    else $error("stage A changed while stalled");

  // The temperature delta and its cold-limit copy stay a constant apart
  c_delta: assert property (@(posedge clk) disable iff (!rst_n)
    c_v_r |-> (c_r.vlow - TEMP_W'(c_r.low)) == TEMP_W'(TEMP_REF + COLD_LIMIT))
    else $error("cold delta mismatch");
`endif

endmodule

### rtl/bptc_corr.sv
// Second-order (cold) correction of TEMP, OFF and SENS.
// Three pipeline stages; depends on bptc_pkg.
module bptc_corr import bptc_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  front_t in_data,
  output logic   out_valid,
  input  logic   out_ready,
  output corr_t  out_data
);

  logic d_v_r, e_v_r, f_v_r;
  logic rdy_d, rdy_e, rdy_f;

  // Stage D: squares
  logic        [RAW_W-1:0]   d_d1_r;
  logic signed [TEMP_W-1:0]  d_temp1_r;
  logic signed [OFF1_W-1:0]  d_off1_r;
  logic signed [SENS1_W-1:0] d_sens1_r;
  logic        [T2_W-1:0]    d_t2_r;
  logic                      d_cold_r, d_vcold_r;
  logic signed [2*LOW_W-1:0] sq_low_nxt;
  logic signed [2*TEMP_W-1:0] sq_vlow_nxt;
  logic        [SQ_W-1:0]    d_sq_r, d_sqv_r;

  // Stage E: correction terms
  logic        [RAW_W-1:0]   e_d1_r;
  logic signed [TEMP_W-1:0]  e_temp_r, e_temp_nxt;
  logic signed [OFF1_W-1:0]  e_off1_r;
  logic signed [SENS1_W-1:0] e_sens1_r;
  logic        [CORR_W-1:0]  e_off2_r, e_off2_nxt;
  logic        [CORR_W-1:0]  e_sens2_r, e_sens2_nxt;
  logic        [SQ_W+1:0]    five_sq;
  logic        [CORR_W-1:0]  seven_sqv, eleven_sqv;

  // Stage F: corrected values
  corr_t f_r, f_nxt;

  assign rdy_f    = !f_v_r || out_ready;
  assign rdy_e    = !e_v_r || rdy_f;
  assign rdy_d    = !d_v_r || rdy_e;
  assign in_ready = rdy_d;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
      e_v_r <= 1'b0;
      f_v_r <= 1'b0;
    end else begin
      if (rdy_d) d_v_r <= in_valid;
      if (rdy_e) e_v_r <= d_v_r;
      if (rdy_f) f_v_r <= e_v_r;
    end
  end

  // Squares of (TEMP-2000) and (TEMP+1500)
  assign sq_low_nxt  = in_data.low * in_data.low;
  assign sq_vlow_nxt = in_data.vlow * in_data.vlow;

  // 5*q/2, 5*q/4, 7*v, 11*v/2 by shifts, adds and one subtract; all terms are non-negative
  always_comb begin
    five_sq    = {d_sq_r, 2'b00} + {2'b00, d_sq_r};
    seven_sqv  = {d_sqv_r, 3'b000} - {3'b000, d_sqv_r};
    eleven_sqv = {d_sqv_r, 3'b000} + {2'b00, d_sqv_r, 1'b0} + {3'b000, d_sqv_r};
    e_off2_nxt  = '0;
    e_sens2_nxt = '0;
    e_temp_nxt  = d_temp1_r;
    if (d_cold_r) begin
      e_off2_nxt  = {2'b00, five_sq[SQ_W+1:1]};
      e_sens2_nxt = {3'b000, five_sq[SQ_W+1:2]};
      e_temp_nxt  = d_temp1_r - $signed({2'b00, d_t2_r});
      if (d_vcold_r) begin
        e_off2_nxt  = e_off2_nxt + seven_sqv;
        e_sens2_nxt = e_sens2_nxt + {1'b0, eleven_sqv[CORR_W-1:1]};
      end
    end
  end

  // OFF -= OFF2, SENS -= SENS2
  always_comb begin
    f_nxt.d1   = e_d1_r;
    f_nxt.temp = e_temp_r;
    f_nxt.off  = FIN_W'(e_off1_r) - $signed({2'b00, e_off2_r});
    f_nxt.sens = FIN_W'(e_sens1_r) - $signed({2'b00, e_sens2_r});
  end

  always_ff @(posedge clk) begin
    if (rdy_d && in_valid) begin
      d_d1_r    <= in_data.d1;
      d_temp1_r <= in_data.temp1;
      d_off1_r  <= in_data.off1;
      d_sens1_r <= in_data.sens1;
      d_t2_r    <= in_data.t2;
      d_cold_r  <= in_data.low[LOW_W-1];
      d_vcold_r <= in_data.vlow[TEMP_W-1];
      d_sq_r    <= sq_low_nxt[SQ_W-1:0];
      d_sqv_r   <= sq_vlow_nxt[SQ_W-1:0];
    end
    if (rdy_e && d_v_r) begin
      e_d1_r    <= d_d1_r;
      e_temp_r  <= e_temp_nxt;
      e_off1_r  <= d_off1_r;
      e_sens1_r <= d_sens1_r;
      e_off2_r  <= e_off2_nxt;
      e_sens2_r <= e_sens2_nxt;
    end
    if (rdy_f && e_v_r) begin
      f_r <= f_nxt;
    end
  end

  assign out_valid = f_v_r;
  assign out_data  = f_r;

`ifndef NO_ASSERTIONS
  // The offset correction never falls below the sensitivity correction
  corr_order: assert property (@(posedge clk) disable iff (!rst_n)
    e_v_r |-> e_off2_r >= e_sens2_r)
    else $error("OFF2 below SENS2");
`endif

endmodule

### rtl/bptc_press.sv
// Pressure: D1*SENS/2^21 - OFF, then /2^15, both truncating toward zero.
// Five pipeline stages, the last one is the output register; depends on bptc_pkg.
module bptc_press import bptc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  corr_t                    in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [PRESS_W-1:0] out_press,
  output logic signed [TEMP_W-1:0]  out_temp
);

  logic g_v_r, h_v_r, i_v_r, j_v_r, k_v_r;
  logic rdy_g, rdy_h, rdy_i, rdy_j, rdy_k;

  // Stage G: split multiply
  logic        [PL_W-1:0]   g_pl_r, g_pl_nxt;
  logic signed [PH_W-1:0]   g_ph_r, g_ph_nxt;
  logic signed [FIN_W-1:0]  g_off_r;
  logic signed [TEMP_W-1:0] g_temp_r;

  // Stage H: full product
  logic signed [WIDE_W-1:0] h_prod_r, h_prod_nxt;
  logic signed [FIN_W-1:0]  h_off_r;
  logic signed [TEMP_W-1:0] h_temp_r;

  // Stage I: product / 2^21
  logic signed [WIDE_W-1:0] i_sum;
  logic signed [Q_W-1:0]    i_q_r;
  logic signed [FIN_W-1:0]  i_off_r;
  logic signed [TEMP_W-1:0] i_temp_r;

  // Stage J: minus offset
  logic signed [X_W-1:0]    j_x_r, j_x_nxt;
  logic signed [TEMP_W-1:0] j_temp_r;

  // Stage K: / 2^15, output register
  logic signed [X_W-1:0]     k_sum;
  logic signed [PRESS_W-1:0] k_press_r;
  logic signed [TEMP_W-1:0]  k_temp_r;

  assign rdy_k    = !k_v_r || out_ready;
  assign rdy_j    = !j_v_r || rdy_k;
  assign rdy_i    = !i_v_r || rdy_j;
  assign rdy_h    = !h_v_r || rdy_i;
  assign rdy_g    = !g_v_r || rdy_h;
  assign in_ready = rdy_g;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_v_r <= 1'b0;
      h_v_r <= 1'b0;
      i_v_r <= 1'b0;
      j_v_r <= 1'b0;
      k_v_r <= 1'b0;
    end else begin
      if (rdy_g) g_v_r <= in_valid;
      if (rdy_h) h_v_r <= g_v_r;
      if (rdy_i) i_v_r <= h_v_r;
      if (rdy_j) j_v_r <= i_v_r;
      if (rdy_k) k_v_r <= j_v_r;
    end
  end

  // D1 times the low and high slices of SENS
  assign g_pl_nxt = PL_W'(in_data.d1) * PL_W'(in_data.sens[SPLIT_W-1:0]);
  assign g_ph_nxt = $signed({1'b0, in_data.d1}) *
                    $signed(in_data.sens[FIN_W-1:SPLIT_W]);

  // Recombine partial products
  assign h_prod_nxt = (WIDE_W'(g_ph_r) <<< SPLIT_W) + $signed(WIDE_W'(g_pl_r));

  // Round toward zero: bias negative values before the floor shift
  assign i_sum   = h_prod_r + $signed({{(WIDE_W-SENS_DIV_SH){1'b0}},
                                       {SENS_DIV_SH{h_prod_r[WIDE_W-1]}}});
  assign j_x_nxt = X_W'(i_q_r) - X_W'(i_off_r);
  assign k_sum   = j_x_r + $signed({{(X_W-PRESS_SH){1'b0}},
                                    {PRESS_SH{j_x_r[X_W-1]}}});

  always_ff @(posedge clk) begin
    if (rdy_g && in_valid) begin
      g_pl_r   <= g_pl_nxt;
      g_ph_r   <= g_ph_nxt;
      g_off_r  <= in_data.off;
      g_temp_r <= in_data.temp;
    end
    if (rdy_h && g_v_r) begin
      h_prod_r <= h_prod_nxt;
      h_off_r  <= g_off_r;
      h_temp_r <= g_temp_r;
    end
    if (rdy_i && h_v_r) begin
      i_q_r    <= $signed(i_sum[WIDE_W-1:SENS_DIV_SH]);
      i_off_r  <= h_off_r;
      i_temp_r <= h_temp_r;
    end
    if (rdy_j && i_v_r) begin
      j_x_r    <= j_x_nxt;
      j_temp_r <= i_temp_r;
    end
    if (rdy_k && j_v_r) begin
      k_press_r <= $signed(k_sum[PRESS_SH+PRESS_W-1:PRESS_SH]);
      k_temp_r  <= j_temp_r;
    end
  end

  assign out_valid = k_v_r;
  assign out_press = k_press_r;
  assign out_temp  = k_temp_r;

`ifndef NO_ASSERTIONS
  // A result only appears behind a filled stage J
  out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(k_v_r) |-> $past(j_v_r))
    else $error("output valid without a source");
`endif

endmodule

### rtl/baro_pressure_temp_compensation_core.sv
// Eleven register stages: three first-order, three cold-correction, five pressure stages.
// Throughput: one request per cycle while out_tready is high; a full stage stalls only
// when the stage after it is full and cannot pass its own data on.
// Reset (rst_n low, synchronous): all stage valid bits and calibration words clear to 0.
// Calibration writes are taken every cycle (cfg_ready is always high).
// Top level; depends on bptc_pkg, bptc_front, bptc_corr and bptc_press.
module baro_pressure_temp_compensation_core import bptc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  // Input stream
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [47:0]      in_tdata,   // [23:0] raw_pressure, [47:24] raw_temperature
  // Result stream
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [47:0]      out_tdata,  // [26:0] comp_pressure, [45:27] temperature_centi, 0
  // Calibration writes
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CAL_W-1:0] cfg_data
);

  cal_t   cal_r;
  front_t front_data;
  corr_t  corr_data;
  logic   front_valid, front_ready;
  logic   corr_valid, corr_ready;
  logic signed [PRESS_W-1:0] press_pa;
  logic signed [TEMP_W-1:0]  temp_centi;

  assign cfg_ready = 1'b1;

  // Calibration register file; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cal_reg_t'(cfg_index))
        REG_PRESSURE_SENSITIVITY:  cal_r.pressure_sensitivity  <= cfg_data;
        REG_PRESSURE_OFFSET:       cal_r.pressure_offset       <= cfg_data;
        REG_SENSITIVITY_TEMP_COEF: cal_r.sensitivity_temp_coef <= cfg_data;
        REG_OFFSET_TEMP_COEF:      cal_r.offset_temp_coef      <= cfg_data;
        REG_REFERENCE_TEMPERATURE: cal_r.reference_temperature <= cfg_data;
        REG_TEMPERATURE_SLOPE:     cal_r.temperature_slope     <= cfg_data;
        default: ;
      endcase
    end
  end

  bptc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cal       (cal_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_d1     (in_tdata[RAW_W-1:0]),
    .in_d2     (in_tdata[2*RAW_W-1:RAW_W]),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .out_data  (front_data)
  );

  bptc_corr u_corr (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_data   (front_data),
    .out_valid (corr_valid),
    .out_ready (corr_ready),
    .out_data  (corr_data)
  );

  bptc_press u_press (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (corr_valid),
    .in_ready  (corr_ready),
    .in_data   (corr_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_press (press_pa),
    .out_temp  (temp_centi)
  );

  // Pack the result, zero fill to whole bytes
  assign out_tdata = {2'b00, temp_centi, press_pa};

`ifndef NO_ASSERTIONS
  // A write to an index past the register list leaves the calibration alone
  cfg_drop: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready && (cfg_index >= REG_COUNT) |=> $stable(cal_r))
    else $error("write to unknown index changed calibration");
`endif

endmodule

### test/baro_pressure_temp_compensation_core_test.sv
// Self-checking bench for baro_pressure_temp_compensation_core: drives reading pairs and
// calibration writes, predicts every result in-bench and checks the result stream.
// Depends on bptc_pkg and the core RTL only.
`timescale 1ns / 100ps

module baro_pressure_temp_compensation_core_test;
  import bptc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 16;   // a bit over the pipeline depth
  localparam logic [RAW_W-1:0] RAW_MAX = {RAW_W{1'b1}};
  localparam logic [CAL_W-1:0] CAL_MAX = {CAL_W{1'b1}};

  typedef struct {
    logic signed [PRESS_W-1:0] comp_pressure;
    logic signed [TEMP_W-1:0]  temperature_centi;
  } compensated_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [47:0]      in_tdata = '0;   // [23:0] raw_pressure, [47:24] raw_temperature
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [47:0]      out_tdata;       // [26:0] comp_pressure, [45:27] temperature_centi
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CAL_W-1:0] cfg_data = '0;

  // Calibration words as the block should hold them
  logic [CAL_W-1:0] cal_word [REG_COUNT];

  compensated_t expected_readings [$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int reading_count = 0;
  int result_count = 0;
  int cal_write_count = 0;
  int cold_hits = 0;
  int very_cold_hits = 0;
  int idle_cycles = 0;

  baro_pressure_temp_compensation_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Second-order compensation of one reading pair with the current calibration
  function automatic compensated_t compensate(input logic [RAW_W-1:0] d1_raw,
                                              input logic [RAW_W-1:0] d2_raw);
    longint d1, d2, c1, c2, c3, c4, c5, c6;
    longint dt, temp, off, sens, t2, low, vlow, off2, sens2, press;
    compensated_t result;
    d1 = longint'(d1_raw);
    d2 = longint'(d2_raw);
    c1 = longint'(cal_word[REG_PRESSURE_SENSITIVITY]);
    c2 = longint'(cal_word[REG_PRESSURE_OFFSET]);
    c3 = longint'(cal_word[REG_SENSITIVITY_TEMP_COEF]);
    c4 = longint'(cal_word[REG_OFFSET_TEMP_COEF]);
    c5 = longint'(cal_word[REG_REFERENCE_TEMPERATURE]);
    c6 = longint'(cal_word[REG_TEMPERATURE_SLOPE]);
    dt = d2 - (c5 << C5_SHIFT);
    temp = TEMP_REF + ((dt * c6) >>> TEMP_SHIFT);
    off = (c2 << C2_SHIFT) + ((c4 * dt) >>> OFF_SHIFT);
    sens = (c1 << C1_SHIFT) + ((c3 * dt) >>> SENS_SHIFT);
    // cold branch decided on the first-order temperature
    if (temp < TEMP_REF) begin
      cold_hits++;
      t2 = (dt * dt) >>> T2_SHIFT;
      low = temp - TEMP_REF;
      off2 = 5 * low * low / 2;
      sens2 = 5 * low * low / 4;
      if (temp < -COLD_LIMIT) begin
        very_cold_hits++;
        vlow = temp + COLD_LIMIT;
        off2 += 7 * vlow * vlow;
        sens2 += 11 * vlow * vlow / 2;
      end
      temp -= t2;
      off -= off2;
      sens -= sens2;
    end
    // C division truncates toward zero, as does SV on signed longint
    press = (d1 * sens / 2097152 - off) / 32768;
    result.comp_pressure = press[PRESS_W-1:0];
    result.temperature_centi = temp[TEMP_W-1:0];
    return result;
  endfunction

  // Raw temperature whose first-order temperature is TEMP_REF + delta (delta <= 0).
  // Returns -1 when the slope word is zero or no such reading fits in 24 bits.
  function automatic longint d2_for_temp(input longint delta);
    longint dt, d2;
    if (cal_word[REG_TEMPERATURE_SLOPE] == '0) return -1;
    dt = -((-delta << TEMP_SHIFT) / longint'(cal_word[REG_TEMPERATURE_SLOPE]));
    d2 = (longint'(cal_word[REG_REFERENCE_TEMPERATURE]) << C5_SHIFT) + dt;
    if (d2 < 0 || d2 > longint'(RAW_MAX)) return -1;
    return d2;
  endfunction

  // One request on the input stream; valid stays high for a following request
  task automatic send_reading(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {d2, d1};
    do @(posedge clk); while (!in_tready);
    expected_readings.push_back(compensate(d1, d2));
    reading_count++;
  endtask

  // Stop sending and wait until the pipeline has emptied
  task automatic quiesce();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_readings.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cal(input logic [IDX_W-1:0] idx, input logic [CAL_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx < REG_COUNT) cal_word[idx] = value;
    cal_write_count++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_calibration(input logic [CAL_W-1:0] c1, input logic [CAL_W-1:0] c2,
                                 input logic [CAL_W-1:0] c3, input logic [CAL_W-1:0] c4,
                                 input logic [CAL_W-1:0] c5, input logic [CAL_W-1:0] c6);
    write_cal(REG_PRESSURE_SENSITIVITY, c1);
    write_cal(REG_PRESSURE_OFFSET, c2);
    write_cal(REG_SENSITIVITY_TEMP_COEF, c3);
    write_cal(REG_OFFSET_TEMP_COEF, c4);
    write_cal(REG_REFERENCE_TEMPERATURE, c5);
    write_cal(REG_TEMPERATURE_SLOPE, c6);
  endtask

  // Calibration word biased toward its extremes
  function automatic logic [CAL_W-1:0] random_cal_word();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return '0;
    if (pick == 1) return CAL_MAX;
    return CAL_W'($urandom);
  endfunction

  // Zero calibration: fixed 20.00 C, pressure from the formulas alone
  task automatic test_unconfigured();
    send_reading('0, '0);
    send_reading(RAW_MAX, RAW_MAX);
    send_reading(RAW_MAX, '0);
    send_reading('0, RAW_MAX);
    quiesce();
  endtask

  // Typical calibration, readings on both sides of the 20.00 C and -15.00 C limits
  task automatic test_temperature_branches();
    set_calibration(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
    send_reading(24'd9085466, 24'd8569150);
    send_reading(RAW_MAX, RAW_W'(d2_for_temp(0)));
    send_reading(24'd9085466, RAW_W'(d2_for_temp(-1)));
    send_reading('0, RAW_W'(d2_for_temp(-3500)));
    send_reading(RAW_MAX, RAW_W'(d2_for_temp(-3501)));
    send_reading(RAW_MAX, '0);
    send_reading(24'h5A5A5A, RAW_MAX);
    send_reading('0, '0);
    quiesce();
  endtask

  // Writes to indexes past the last register must leave calibration untouched
  task automatic test_ignored_index();
    write_cal(REG_COUNT, CAL_MAX);
    write_cal(IDX_W'(REG_COUNT + 1), 16'hA5A5);
    send_reading(RAW_MAX, RAW_MAX);
    send_reading(24'h5A5A5A, 24'hA5A5A5);
    quiesce();
  endtask

  task automatic test_full_scale_cal();
    set_calibration(CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX);
    send_reading('0, '0);
    send_reading(RAW_MAX, RAW_MAX);
    send_reading(RAW_MAX, '0);
    send_reading('0, RAW_MAX);
    send_reading(RAW_MAX, RAW_W'(d2_for_temp(-3501)));
    quiesce();
  endtask

  // Random readings in two calibration sets, draining in between
  task automatic test_random_readings(input int idle_pct, input int stall_pct,
                                      input int count);
    logic [RAW_W-1:0] d1;
    longint d2;
    int mode;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (2) begin
      set_calibration(random_cal_word(), random_cal_word(), random_cal_word(),
                      random_cal_word(), random_cal_word(), random_cal_word());
      repeat (count / 2) begin
        mode = $urandom_range(3);
        d1 = RAW_W'($urandom);
        if ($urandom_range(15) == 0) d1 = $urandom_range(1) ? RAW_MAX : '0;
        if (mode <= 1) begin
          // near the reference temperature, where real readings sit
          d2 = (longint'(cal_word[REG_REFERENCE_TEMPERATURE]) << C5_SHIFT)
               + longint'($urandom_range(1 << 22)) - (1 << 21);
        end else if (mode == 2) begin
          d2 = d2_for_temp(-longint'($urandom_range(4000)));
        end else begin
          d2 = -1;
        end
        if (d2 < 0 || d2 > longint'(RAW_MAX)) d2 = longint'(RAW_W'($urandom));
        send_reading(d1, RAW_W'(d2));
      end
      // sender holds off until every result is back
      quiesce();
    end
  endtask

  // Result checking, receiver stalls and watchdog
  always @(posedge clk) begin
    compensated_t want;
    logic signed [PRESS_W-1:0] got_press;
    logic signed [TEMP_W-1:0]  got_temp;
    got_press = out_tdata[PRESS_W-1:0];
    got_temp = out_tdata[PRESS_W +: TEMP_W];
    if (rst_n && out_tvalid && out_tready) begin
      result_count++;
      if (expected_readings.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result: pressure %0d temperature %0d", got_press, got_temp);
        mismatch_count++;
      end else begin
        want = expected_readings.pop_front();
        if (got_press !== want.comp_pressure || got_temp !== want.temperature_centi) begin
          if (mismatch_count < 10)
            $display("result %0d: expected pressure %0d temperature %0d, got %0d %0d",
                     result_count, want.comp_pressure, want.temperature_centi,
                     got_press, got_temp);
          mismatch_count++;
        end
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
      $display("baro_pressure_temp_compensation_core: mismatch");
      $finish;
    end
  end

  initial begin
    foreach (cal_word[i]) cal_word[i] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_unconfigured();
    test_temperature_branches();
    test_ignored_index();
    test_full_scale_cal();

    test_random_readings(0, 0, 400);
    test_random_readings(57, 0, 400);
    test_random_readings(0, 57, 400);
    test_random_readings(19, 19, 400);

    $display("sent %0d reading pairs, checked %0d results, %0d calibration writes",
             reading_count, result_count, cal_write_count);
    $display("below 20.00 C: %0d, below -15.00 C: %0d, mismatches: %0d",
             cold_hits, very_cold_hits, mismatch_count);
    if (mismatch_count == 0 && expected_readings.size() == 0)
      $display("baro_pressure_temp_compensation_core: match");
    else
      $display("baro_pressure_temp_compensation_core: mismatch");
    $finish;
  end

endmodule
